// File: design/spq_pkg.sv
// Shared constants and types for the sorted priority queue.
package spq_pkg;

   // Number of cells in the chain
   localparam int DEPTH = 16;
   // Counter width: holds 0 to DEPTH
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VAL_W = 32;
   localparam int OP_W = 2;
   localparam int RSP_CNT_W = 5;

   // Request opcodes
   localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
   localparam logic [OP_W-1:0] OP_POP    = 2'd1;
   localparam logic [OP_W-1:0] OP_STATUS = 2'd2;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic                     push;
      logic                     pop;
      logic signed [VAL_W-1:0]  value;
   } cell_cmd_type;

endpackage

// File: design/spq_cell.sv
// One storage cell of the sorted chain: holds an entry and trades with its neighbours.
module spq_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  spq_pkg::cell_cmd_type           cmd,
   input  logic                            left_valid,
   input  logic                            left_ge,
   input  logic signed [spq_pkg::VAL_W-1:0] left_entry,
   input  logic                            right_valid,
   input  logic signed [spq_pkg::VAL_W-1:0] right_entry,
   output logic                            valid,
   output logic                            ge,
   output logic signed [spq_pkg::VAL_W-1:0] entry
);
   import spq_pkg::*;

   logic                    valid_ff;
   logic                    valid_in;
   logic signed [VAL_W-1:0] entry_ff;
   logic signed [VAL_W-1:0] entry_in;

   // Flag an entry that stays ahead of the incoming request value
   assign ge = valid_ff && (entry_ff >= cmd.value);

   // Keep, take the new value, or shift from a neighbour
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (cmd.push) begin
         valid_in = valid_ff | left_valid;
         if (!ge) begin
            entry_in = left_ge ? cmd.value : left_entry;
         end
      end else if (cmd.pop) begin
         valid_in = right_valid;
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload without reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

// File: design/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: request decode, cell chain and result register.
//
// Max-first priority queue kept in descending order across a chain of DEPTH cells.
// Request channel: drive req_opcode and req_value with start high; the request is
// taken at a rising edge where start is high and busy is low. Opcodes: push value,
// pop largest, status only (the unused code acts as status only).
// A push finds its place in every cell at once by local comparison and the tail of
// the list moves one cell down; a pop moves every cell up by one. Equal values
// leave in arrival order. A push to a full queue is dropped and flagged.
// Result channel: exactly one result per request, shown for one cycle with rsp_valid
// high in the cycle after the request is taken. It carries the largest value (0 when
// empty), the count, the empty and full flags and the dropped flag.
// Throughput: one request per cycle while busy is low; every request completes in its
// cell update, so busy is low except during reset and just after it.
// Reset empties the queue; the cell contents are left as they are.
// The receiver cannot stall: a result not taken in its cycle is lost.
module sorted_priority_queue_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [spq_pkg::OP_W-1:0]           req_opcode,
   input  logic signed [spq_pkg::VAL_W-1:0]   req_value,
   output logic                               rsp_valid,
   output logic signed [spq_pkg::VAL_W-1:0]   rsp_top_value,
   output logic [spq_pkg::RSP_CNT_W-1:0]      rsp_count,
   output logic                               rsp_is_empty,
   output logic                               rsp_is_full,
   output logic                               rsp_push_dropped
);
   import spq_pkg::*;

   logic                    accept;
   logic                    full;
   logic                    empty;
   cell_cmd_type            cmd;
   logic                    busy_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    rsp_valid_ff;
   logic                    dropped_ff;
   logic                    dropped_in;

   logic                    cell_valid [DEPTH];
   logic                    cell_ge    [DEPTH];
   logic signed [VAL_W-1:0] cell_entry [DEPTH];

   assign accept = start && !busy_ff;
   assign full   = cell_valid[DEPTH-1];
   assign empty  = !cell_valid[0];

   // Decode the request into a chain command
   always_comb begin
      cmd.push   = 1'b0;
      cmd.pop    = 1'b0;
      cmd.value  = req_value;
      dropped_in = 1'b0;
      count_in   = count_ff;
      if (accept) begin
         case (req_opcode)
            OP_PUSH: begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  cmd.push = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_POP: begin
               if (!empty) begin
                  cmd.pop  = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            OP_STATUS: begin
               count_in = count_ff;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   // Build the chain; the ends see a full left and an empty right
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                    lv;
      logic                    lg;
      logic signed [VAL_W-1:0] le;
      logic                    rv;
      logic signed [VAL_W-1:0] re;
      if (i == 0) begin : g_head
         assign lv = 1'b1;
         assign lg = 1'b1;
         assign le = req_value;
      end else begin : g_mid
         assign lv = cell_valid[i-1];
         assign lg = cell_ge[i-1];
         assign le = cell_entry[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign rv = 1'b0;
         assign re = '0;
      end else begin : g_body
         assign rv = cell_valid[i+1];
         assign re = cell_entry[i+1];
      end
      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_valid  (lv),
         .left_ge     (lg),
         .left_entry  (le),
         .right_valid (rv),
         .right_entry (re),
         .valid       (cell_valid[i]),
         .ge          (cell_ge[i]),
         .entry       (cell_entry[i])
      );
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      dropped_ff <= dropped_in;
   end

   // Report the queue as it stands after the request
   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_top_value    = empty ? '0 : cell_entry[0];
   assign rsp_count        = RSP_CNT_W'(count_ff);
   assign rsp_is_empty     = empty;
   assign rsp_is_full      = full;
   assign rsp_push_dropped = dropped_ff;

endmodule
